### src/brd_pkg.sv
// Shared definitions for the byte ring deque: field widths, operation and
// status codes, and the default store depth. No dependencies.

package brd_pkg;

    localparam int DEPTH_DEFAULT = 1024;

    localparam int OPCODE_W    = 3;
    localparam int BYTE_W      = 8;
    localparam int AMOUNT_W    = 10;
    localparam int OFFSET_W    = 10;
    localparam int OCCUPANCY_W = 10;
    localparam int STATUS_W    = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ       = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

endpackage

### src/brd_ifs.sv
// Valid/ready channel interfaces for the byte ring deque: the operation
// channel and the result channel. Depends on brd_pkg.

interface brd_cmd_if;
    import brd_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [BYTE_W-1:0]   data_byte;
    logic [AMOUNT_W-1:0] amount;
    logic [OFFSET_W-1:0] offset;
    logic                end_of_burst;

    modport source (
        output valid, opcode, data_byte, amount, offset, end_of_burst,
        input  ready
    );
    modport sink (
        input  valid, opcode, data_byte, amount, offset, end_of_burst,
        output ready
    );
endinterface

interface brd_rsp_if;
    import brd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [BYTE_W-1:0]      read_byte;
    logic [OCCUPANCY_W-1:0] occupancy;
    logic [STATUS_W-1:0]    status;
    logic                   burst_done;

    modport source (
        output valid, read_byte, occupancy, status, burst_done,
        input  ready
    );
    modport sink (
        input  valid, read_byte, occupancy, status, burst_done,
        output ready
    );
endinterface

### src/brd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.

module brd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/byte_ring_deque.sv
// Top level of the byte ring deque: pointer logic, result pipeline and the
// byte store. Depends on brd_pkg, brd_cmd_if, brd_rsp_if and brd_ram.

// Usage
// The cmd channel carries one operation per transfer: push a byte at the
// back or front, pop a number of bytes from the front or back, or read the
// byte at an offset from the front. The rsp channel returns exactly one
// result per operation, in order: the byte read (zero unless a read
// succeeded), the occupancy after the operation, a status code and the
// burst echo for pushes.
// rsp.valid rises once the result has passed the first stage and the output
// register. One operation is taken every cycle while the receiver does not
// stall: a push or pop updates the head or tail pointer, and each operation
// makes at most one access to the single byte store, whose registered read
// port is why a result passes a first stage before the output register.
// The store holds at most DEPTH-1 bytes; one slot always stays free.
// Rejected operations (push when full, pop beyond the occupancy, read out of
// range) report a status and leave the pointers untouched.
// Reset empties the deque by clearing both pointers; the byte store itself
// is not cleared, since only bytes within the occupancy are ever read.
// When the receiver stalls, the finished result waits in the output
// register and one more operation may still be taken into the first stage;
// cmd.ready then drops until the output register drains.

module byte_ring_deque #(
    parameter int DEPTH = brd_pkg::DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    brd_cmd_if.sink    cmd,
    brd_rsp_if.source  rsp
);
    import brd_pkg::*;

    localparam int PW = $clog2(DEPTH);
    // Wide enough for any sum of a pointer and an amount or offset.
    localparam int XW = ((PW > AMOUNT_W) ? PW : AMOUNT_W) + 2;
    localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

    // Pointers.
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;

    // First stage: result fields waiting for the store's read data.
    logic                   a_valid_reg;
    logic [OCCUPANCY_W-1:0] a_occ_reg;
    status_t                a_status_reg;
    logic                   a_done_reg;
    logic                   a_rd_reg;

    // Output register.
    logic                   b_valid_reg;
    logic [BYTE_W-1:0]      b_byte_reg;
    logic [OCCUPANCY_W-1:0] b_occ_reg;
    status_t                b_status_reg;
    logic                   b_done_reg;

    logic accept;
    logic a_adv;

    logic [XW-1:0] head_x, tail_x, occ_x, amount_x, offset_x;
    logic [XW-1:0] occ_after;
    logic [XW-1:0] tail_inc, head_dec, head_add, tail_sub, rd_sum;
    logic          is_full;

    status_t       status_next;
    logic          done_next;
    logic          rd_ok;

    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic          ram_re;
    logic [PW-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    // Handshake: the first stage moves on when the output register is free
    // or is being emptied in this cycle.
    assign a_adv     = a_valid_reg && (!b_valid_reg || rsp.ready);
    assign cmd.ready = !a_valid_reg || a_adv;
    assign accept    = cmd.valid && cmd.ready;

    // Arithmetic on the pointers; every sum stays below twice the depth,
    // so one compare and subtract wraps it.
    always_comb
    begin
        head_x   = XW'(head_reg);
        tail_x   = XW'(tail_reg);
        amount_x = XW'(cmd.amount);
        offset_x = XW'(cmd.offset);

        occ_x   = (tail_x >= head_x) ? (tail_x - head_x) : (tail_x + DEPTH_X - head_x);
        is_full = (occ_x >= DEPTH_X - XW'(1));

        tail_inc = tail_x + XW'(1);
        if (tail_inc == DEPTH_X)
        begin
            tail_inc = '0;
        end

        head_dec = (head_x == '0) ? (DEPTH_X - XW'(1)) : (head_x - XW'(1));

        head_add = head_x + amount_x;
        if (head_add >= DEPTH_X)
        begin
            head_add = head_add - DEPTH_X;
        end

        tail_sub = (tail_x >= amount_x) ? (tail_x - amount_x)
                                        : (tail_x + DEPTH_X - amount_x);

        rd_sum = head_x + offset_x;
        if (rd_sum >= DEPTH_X)
        begin
            rd_sum = rd_sum - DEPTH_X;
        end
    end

    // Operation decode.
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        status_next = ST_OK;
        done_next   = 1'b0;
        rd_ok       = 1'b0;
        occ_after   = occ_x;
        ram_we      = 1'b0;
        ram_waddr   = tail_reg;
        ram_re      = 1'b0;
        ram_raddr   = rd_sum[PW-1:0];

        case (op_t'(cmd.opcode))
            OP_PUSH_BACK:
            begin
                done_next = cmd.end_of_burst;
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ram_we    = accept;
                    ram_waddr = tail_reg;
                    tail_next = tail_inc[PW-1:0];
                    occ_after = occ_x + XW'(1);
                end
            end
            OP_PUSH_FRONT:
            begin
                done_next = cmd.end_of_burst;
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ram_we    = accept;
                    ram_waddr = head_dec[PW-1:0];
                    head_next = head_dec[PW-1:0];
                    occ_after = occ_x + XW'(1);
                end
            end
            OP_POP_FRONT:
            begin
                if (amount_x > occ_x)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    head_next = head_add[PW-1:0];
                    occ_after = occ_x - amount_x;
                end
            end
            OP_POP_BACK:
            begin
                if (amount_x > occ_x)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    tail_next = tail_sub[PW-1:0];
                    occ_after = occ_x - amount_x;
                end
            end
            OP_READ:
            begin
                if (offset_x >= occ_x)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    rd_ok  = 1'b1;
                    ram_re = accept;
                end
            end
            default:
            begin
            end
        endcase
    end

    brd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.data_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pointer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else if (accept)
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // First stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    // First stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_occ_reg    <= occ_after[OCCUPANCY_W-1:0];
            a_status_reg <= status_next;
            a_done_reg   <= done_next;
            a_rd_reg     <= rd_ok;
        end
    end

    // Output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (a_adv)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    // Output register payload; the store's read data is held until the
    // first stage moves on, since a read is only issued on a transfer.
    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            b_byte_reg   <= a_rd_reg ? ram_rdata : '0;
            b_occ_reg    <= a_occ_reg;
            b_status_reg <= a_status_reg;
            b_done_reg   <= a_done_reg;
        end
    end

    assign rsp.valid      = b_valid_reg;
    assign rsp.read_byte  = b_byte_reg;
    assign rsp.occupancy  = b_occ_reg;
    assign rsp.status     = b_status_reg;
    assign rsp.burst_done = b_done_reg;

    // The deque never holds more than DEPTH-1 bytes.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_x <= DEPTH_X - XW'(1))
        else $error("occupancy exceeds capacity");

    // An accepted push with room grows the occupancy by exactly one.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_full && (cmd.opcode == OP_PUSH_BACK || cmd.opcode == OP_PUSH_FRONT))
        |=> (occ_x == $past(occ_x) + XW'(1)))
        else $error("push did not advance the occupancy");

    // A read out of range is reported as such in the first stage.
    a_range_status: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.opcode == OP_READ && offset_x >= occ_x)
        |=> (a_valid_reg && a_status_reg == ST_RANGE && !a_rd_reg))
        else $error("out of range read not flagged");

    // A rejected result carries a zero byte.
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_status_reg != ST_OK) |-> (b_byte_reg == '0))
        else $error("rejected operation returned a byte");

endmodule
